FILE: hw/rtl/pte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piece table edit engine package
// Shared constants, descriptor, request/response and cell control types.
// ----------------------------------------------------------------------------
package pte_pkg;

   localparam int MAX_PIECES     = 32;
   localparam int APPEND_SPACE   = 1048576;
   localparam int TEXT_ADDR_BITS = 20;

   // field widths of the request/response payload
   localparam int FIELD_W = TEXT_ADDR_BITS;
   localparam int TOTAL_W = 6;

   // internal widths
   localparam int IDX_W = $clog2(MAX_PIECES);
   localparam int CNT_W = $clog2(MAX_PIECES + 1);
   localparam int AU_W  = $clog2(APPEND_SPACE + 1);
   localparam int TXT_W = FIELD_W + 2;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LIST   = 2'd2,
      OP_INIT   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_RANGE  = 2'd2,
      ST_APPEND = 2'd3
   } status_type;

   typedef struct packed {
      logic               src;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] len;
   } desc_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] length;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] append_start;
      logic               piece_source;
      logic [FIELD_W-1:0] piece_start;
      logic [FIELD_W-1:0] piece_length;
      logic [TOTAL_W-1:0] piece_total;
      logic               last;
   } rsp_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic             pop;
      logic             push;
      logic [IDX_W-1:0] wr_idx;
   } chain_ctl_type;

endpackage

FILE: hw/rtl/pte_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piece table cell
// Holds one descriptor; shifts towards the head on pop, loads the push bus
// when it is the write slot.
// ----------------------------------------------------------------------------
module pte_cell (
   input  logic                  clock,
   input  logic [pte_pkg::IDX_W-1:0] cell_idx,
   input  pte_pkg::chain_ctl_type ctl,
   input  pte_pkg::desc_type     right_desc,
   input  pte_pkg::desc_type     push_desc,
   output pte_pkg::desc_type     desc
);
   import pte_pkg::*;

   desc_type desc_ff;
   desc_type desc_in;
   logic     hit;

   assign hit  = ctl.push && (ctl.wr_idx == cell_idx);
   assign desc = desc_ff;

   // choose between push bus, neighbour and hold
   always_comb begin
      desc_in = desc_ff;
      if (hit) begin
         desc_in = push_desc;
      end else if (ctl.pop) begin
         desc_in = right_desc;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

endmodule

FILE: hw/rtl/pte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piece table controller
// Checks requests, walks the cell chain from its head and steers pops and
// pushes; keeps count, text length, append usage and the response register.
// ----------------------------------------------------------------------------
module pte_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  pte_pkg::req_type            req_item,
   output logic                        rsp_valid,
   output pte_pkg::rsp_type            rsp_item,
   input  logic                        csr_wr_en,
   input  logic [pte_pkg::FIELD_W-1:0] csr_wr_data,
   input  pte_pkg::desc_type           head_desc,
   output pte_pkg::chain_ctl_type      ctl,
   output pte_pkg::desc_type           push_desc
);
   import pte_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LIST,
      S_SCAN,
      S_EDIT
   } state_type;

   localparam logic [AU_W:0]    SPACE_LIM = (AU_W + 1)'(APPEND_SPACE);
   localparam logic [CNT_W+1:0] MAX_LIM   = (CNT_W + 2)'(MAX_PIECES);

   state_type          state_ff, state_in;
   opcode_type         op_ff, op_in;
   logic [FIELD_W-1:0] off_ff, off_in;
   logic [FIELD_W-1:0] len_ff, len_in;
   logic [FIELD_W-1:0] orig_ff, orig_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [TXT_W-1:0]   total_ff, total_in;
   logic [TXT_W-1:0]   pos_ff, pos_in;
   logic [AU_W-1:0]    append_ff, append_in;
   logic [1:0]         sub_ff, sub_in;
   logic               placed_ff, placed_in;
   logic               split_ff, split_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               init_load;
   logic [TXT_W-1:0]   pe;
   logic [TXT_W-1:0]   end_pos;
   logic [TXT_W-1:0]   off_x;
   logic [TXT_W-1:0]   req_off_x;
   logic [TXT_W-1:0]   req_end;
   logic [FIELD_W-1:0] k;
   logic               ins;
   logic               hit;
   logic [CNT_W+1:0]   need;
   desc_type           new_desc;
   logic [CNT_W-1:0]   cnt_after;

   function automatic rsp_type make_rsp(status_type st, logic [FIELD_W-1:0] as,
                                        desc_type d, logic [CNT_W-1:0] tot,
                                        logic lst);
      rsp_type r;
      r.status       = st;
      r.append_start = as;
      r.piece_source = d.src;
      r.piece_start  = d.start;
      r.piece_length = d.len;
      r.piece_total  = TOTAL_W'(tot);
      r.last         = lst;
      return r;
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign ins       = (op_ff == OP_INSERT);
   assign off_x     = TXT_W'(off_ff);
   assign pe        = pos_ff + TXT_W'(head_desc.len);
   assign end_pos   = TXT_W'(off_ff) + TXT_W'(len_ff);
   assign k         = FIELD_W'(off_x - pos_ff);
   assign req_off_x = TXT_W'(req_item.offset);
   assign req_end   = TXT_W'(req_item.offset) + TXT_W'(req_item.length);
   assign new_desc  = '{src: 1'b1, start: append_ff[FIELD_W-1:0], len: len_ff};

   // next state, chain steering and response
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      off_in       = off_ff;
      len_in       = len_ff;
      orig_in      = orig_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      append_in    = append_ff;
      sub_in       = sub_ff;
      placed_in    = placed_ff;
      split_in     = split_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      push_desc    = head_desc;
      init_load    = 1'b0;
      hit          = 1'b0;
      need         = '0;
      cnt_after    = cnt_ff;

      if (csr_wr_en) begin
         orig_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_item.opcode;
               off_in = req_item.offset;
               len_in = req_item.length;
               case (req_item.opcode)
                  OP_LIST: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(ST_OK, '0, '0, cnt_ff, 1'b1);
                     end else begin
                        rem_in   = cnt_ff;
                        state_in = S_LIST;
                     end
                  end
                  OP_INIT: begin
                     // rebuild as one original piece, or as an empty table when its length is zero
                     init_load  = 1'b1;
                     ctl.push   = (orig_ff != '0);
                     ctl.wr_idx = '0;
                     push_desc  = '{src: 1'b0, start: '0, len: orig_ff};
                     cnt_in     = (orig_ff != '0) ? CNT_W'(1) : '0;
                     total_in   = TXT_W'(orig_ff);
                     append_in  = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in = make_rsp(ST_OK, '0, '0, cnt_in, 1'b1);
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     if (((req_item.opcode == OP_INSERT) && (req_off_x > total_ff)) ||
                         ((req_item.opcode == OP_DELETE) && (req_end > total_ff))) begin
                        rsp_in = make_rsp(ST_RANGE, '0, '0, cnt_ff, 1'b1);
                     end else if (req_item.length == '0) begin
                        rsp_in = make_rsp(ST_OK,
                           (req_item.opcode == OP_INSERT) ? append_ff[FIELD_W-1:0] : '0,
                           '0, cnt_ff, 1'b1);
                     end else if ((req_item.opcode == OP_INSERT) &&
                                  ((AU_W + 1)'(append_ff) + (AU_W + 1)'(req_item.length)
                                   > SPACE_LIM)) begin
                        rsp_in = make_rsp(ST_APPEND, '0, '0, cnt_ff, 1'b1);
                     end else begin
                        // accepted edit: pre-scan only when the table could overflow
                        rsp_valid_in = 1'b0;
                        rem_in    = cnt_ff;
                        pos_in    = '0;
                        sub_in    = '0;
                        placed_in = 1'b0;
                        split_in  = 1'b0;
                        state_in  = ((CNT_W + 2)'(cnt_ff) + (CNT_W + 2)'(2) > MAX_LIM) ?
                                    S_SCAN : S_EDIT;
                     end
                  end
               endcase
            end
         end

         S_LIST: begin
            // emit head and rotate it to the tail
            ctl.pop  = 1'b1;
            ctl.push = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in = make_rsp(ST_OK, '0, head_desc, cnt_ff, rem_ff == CNT_W'(1));
            rem_in = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end

         S_SCAN: begin
            // rotate once round, noting whether a piece must split
            ctl.pop  = 1'b1;
            ctl.push = 1'b1;
            pos_in   = pe;
            hit      = ins ? ((pos_ff < off_x) && (off_x < pe))
                           : ((pos_ff < off_x) && (end_pos < pe));
            split_in = split_ff | hit;
            rem_in   = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               need = (CNT_W + 2)'(cnt_ff) + (CNT_W + 2)'(ins) + (CNT_W + 2)'(split_ff | hit);
               if (need > MAX_LIM) begin
                  rsp_valid_in = 1'b1;
                  rsp_in   = make_rsp(ST_FULL, '0, '0, cnt_ff, 1'b1);
                  state_in = S_IDLE;
               end else begin
                  rem_in    = cnt_ff;
                  pos_in    = '0;
                  sub_in    = '0;
                  placed_in = 1'b0;
                  state_in  = S_EDIT;
               end
            end
         end

         S_EDIT: begin
            if (rem_ff == '0) begin
               // tail: append new piece if not yet placed, then finish
               if (ins && !placed_ff) begin
                  ctl.push  = 1'b1;
                  push_desc = new_desc;
               end
               cnt_after = cnt_ff + CNT_W'(ctl.push);
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(ST_OK, ins ? append_ff[FIELD_W-1:0] : '0, '0,
                                 cnt_after, 1'b1);
               if (ins) begin
                  total_in  = total_ff + TXT_W'(len_ff);
                  append_in = append_ff + AU_W'(len_ff);
               end else begin
                  total_in  = total_ff - TXT_W'(len_ff);
               end
               state_in = S_IDLE;
            end else begin
               if (ins) begin
                  if (!placed_ff && (off_x <= pos_ff)) begin
                     // new piece goes before the head
                     ctl.push = 1'b1;
                     if (sub_ff == 2'd0) begin
                        push_desc = new_desc;
                        sub_in    = 2'd1;
                     end else begin
                        ctl.pop   = 1'b1;
                        placed_in = 1'b1;
                     end
                  end else if (!placed_ff && (off_x < pe)) begin
                     // split the head round the new piece
                     ctl.push = 1'b1;
                     case (sub_ff)
                        2'd0: begin
                           push_desc.len = k;
                           sub_in = 2'd1;
                        end
                        2'd1: begin
                           push_desc = new_desc;
                           sub_in = 2'd2;
                        end
                        default: begin
                           ctl.pop         = 1'b1;
                           push_desc.start = head_desc.start + k;
                           push_desc.len   = head_desc.len - k;
                           placed_in       = 1'b1;
                        end
                     endcase
                  end else begin
                     ctl.pop  = 1'b1;
                     ctl.push = 1'b1;
                  end
               end else begin
                  if ((pe <= off_x) || (pos_ff >= end_pos)) begin
                     ctl.pop  = 1'b1;
                     ctl.push = 1'b1;
                  end else if ((off_x > pos_ff) && (end_pos < pe)) begin
                     // delete inside one piece: keep both ends
                     ctl.push = 1'b1;
                     if (sub_ff == 2'd0) begin
                        push_desc.len = k;
                        sub_in = 2'd1;
                     end else begin
                        ctl.pop         = 1'b1;
                        push_desc.start = head_desc.start + FIELD_W'(end_pos - pos_ff);
                        push_desc.len   = FIELD_W'(pe - end_pos);
                     end
                  end else if (off_x > pos_ff) begin
                     // trim the tail of the head
                     ctl.pop       = 1'b1;
                     ctl.push      = 1'b1;
                     push_desc.len = k;
                  end else if (end_pos < pe) begin
                     // trim the front of the head
                     ctl.pop         = 1'b1;
                     ctl.push        = 1'b1;
                     push_desc.start = head_desc.start + FIELD_W'(end_pos - pos_ff);
                     push_desc.len   = FIELD_W'(pe - end_pos);
                  end else begin
                     // drop the whole piece
                     ctl.pop = 1'b1;
                  end
               end
               if (ctl.pop) begin
                  pos_in = pe;
                  rem_in = rem_ff - CNT_W'(1);
                  sub_in = 2'd0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // write slot is the tail after any pop
      if (!init_load) begin
         ctl.wr_idx = ctl.pop ? IDX_W'(cnt_ff - CNT_W'(1)) : IDX_W'(cnt_ff);
         cnt_in     = cnt_ff + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         total_ff     <= '0;
         append_ff    <= '0;
         orig_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
         sub_ff       <= '0;
         placed_ff    <= 1'b0;
         split_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         append_ff    <= append_in;
         orig_ff      <= orig_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
         sub_ff       <= sub_in;
         placed_ff    <= placed_in;
         split_ff     <= split_in;
      end
      op_ff  <= op_in;
      off_ff <= off_in;
      len_ff <= len_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   // table never holds more than its capacity
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_PIECES))
      else $error("piece count above capacity");

   // an empty text and an empty table go together between requests
   a_total_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((total_ff == '0) == (cnt_ff == '0)))
      else $error("text length and piece count disagree");

   // a non-final response is always followed by more work
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> busy)
      else $error("list response without last while idle");

   // list of an empty table answers at once
   a_empty_list: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.opcode == OP_LIST) && (cnt_ff == '0))
      |=> (rsp_valid_ff && rsp_ff.last && !busy))
      else $error("empty list did not answer in one cycle");

endmodule

FILE: hw/rtl/piece_table_edit_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piece table edit engine
// Ordered table of piece descriptors held in a chain of cells, with a
// controller that walks and rewrites it one request at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every result shows on
// rsp_item for one cycle with rsp_valid high and cannot be held off, so the
// receiver must take it then. Range and append-space rejections, zero-length
// edits and initialise answer in the cycle after acceptance. List gives one
// result per piece. Insert and delete rotate the table once through the cell
// chain; an insert in front of a piece pushes the new piece first, an insert
// that splits a piece pushes its front, the new piece and its rest in turn, a
// delete that splits one pushes both ends in turn, and a final step answers.
// When fewer than two entries are free, a check pass that rotates the table
// once comes first, and a full-table rejection answers at its end. The head
// cell of the chain is the only read point.
// ----------------------------------------------------------------------------
module piece_table_edit_engine_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  pte_pkg::req_type            req_item,
   output logic                        rsp_valid,
   output pte_pkg::rsp_type            rsp_item,
   input  logic                        csr_wr_en,
   input  logic [pte_pkg::FIELD_W-1:0] csr_wr_data
);
   import pte_pkg::*;

   chain_ctl_type ctl;
   desc_type      push_desc;
   desc_type      cell_desc [MAX_PIECES];
   desc_type      right_desc [MAX_PIECES];

   pte_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_desc   (cell_desc[0]),
      .ctl         (ctl),
      .push_desc   (push_desc)
   );

   // chain of descriptor cells, head at index zero
   for (genvar g = 0; g < MAX_PIECES; g++) begin : g_cell
      if (g == MAX_PIECES - 1) begin : g_end
         assign right_desc[g] = '0;
      end else begin : g_mid
         assign right_desc[g] = cell_desc[g+1];
      end

      pte_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(g)),
         .ctl        (ctl),
         .right_desc (right_desc[g]),
         .push_desc  (push_desc),
         .desc       (cell_desc[g])
      );
   end

endmodule

FILE: verif/piece_table_edit_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piece table edit engine testbench
// Drives insert, delete, list and initialise requests in random bursts.
// A shadow piece table predicts every response. Each response is checked
// field by field against the oldest expected one. Several original lengths
// are used, the extremes among them.
// ----------------------------------------------------------------------------
module piece_table_edit_engine_top_tb;
   import pte_pkg::*;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_item;
   logic                rsp_valid;
   rsp_type             rsp_item;
   logic                csr_wr_en;
   logic [FIELD_W-1:0]  csr_wr_data;

   piece_table_edit_engine_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow piece table
   logic               tbl_src   [MAX_PIECES];
   logic [FIELD_W-1:0] tbl_start [MAX_PIECES];
   logic [FIELD_W-1:0] tbl_len   [MAX_PIECES];
   int                 tbl_count;
   longint             append_fill;
   logic [FIELD_W-1:0] orig_len;

   // rebuilt table of an edit
   logic               nxt_src   [MAX_PIECES+2];
   logic [FIELD_W-1:0] nxt_start [MAX_PIECES+2];
   logic [FIELD_W-1:0] nxt_len   [MAX_PIECES+2];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors;
   logic    taken;
   int      burst_left;
   int      gap_left;
   int      idle_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint text_length();
      longint t;
      t = 0;
      for (int i = 0; i < tbl_count; i++) t += tbl_len[i];
      return t;
   endfunction

   function automatic void add_piece(ref int n, input logic s, input logic [FIELD_W-1:0] st,
                                     input longint ln);
      if (ln == 0 || n >= MAX_PIECES + 2) return;
      nxt_src[n]   = s;
      nxt_start[n] = st;
      nxt_len[n]   = ln[FIELD_W-1:0];
      n++;
   endfunction

   function automatic void push_rsp(status_type st, logic [FIELD_W-1:0] ast);
      rsp_type r;
      r = '0;
      r.status       = st;
      r.append_start = ast;
      r.piece_total  = tbl_count[TOTAL_W-1:0];
      r.last         = 1'b1;
      expected_rsps.push_back(r);
   endfunction

   // apply one request to the shadow table and queue its responses
   function automatic void predict_edit(req_type q);
      longint off, len, pos, l, pe, tot;
      int n;
      logic placed;
      logic [FIELD_W-1:0] ast;
      rsp_type r;
      off = q.offset;
      len = q.length;
      pos = 0;
      n = 0;
      placed = 1'b0;
      tot = text_length();
      case (q.opcode)
         OP_LIST: begin
            if (tbl_count == 0) push_rsp(ST_OK, '0);
            for (int i = 0; i < tbl_count; i++) begin
               r = '0;
               r.status       = ST_OK;
               r.piece_source = tbl_src[i];
               r.piece_start  = tbl_start[i];
               r.piece_length = tbl_len[i];
               r.piece_total  = tbl_count[TOTAL_W-1:0];
               r.last         = (i + 1 == tbl_count);
               expected_rsps.push_back(r);
            end
         end
         OP_INIT: begin
            append_fill = 0;
            tbl_count = 0;
            if (orig_len != 0) begin
               tbl_src[0] = 1'b0;
               tbl_start[0] = '0;
               tbl_len[0] = orig_len;
               tbl_count = 1;
            end
            push_rsp(ST_OK, '0);
         end
         OP_INSERT: begin
            if (off > tot) push_rsp(ST_RANGE, '0);
            else if (len == 0) push_rsp(ST_OK, append_fill[FIELD_W-1:0]);
            else if (append_fill + len > APPEND_SPACE) push_rsp(ST_APPEND, '0);
            else begin
               ast = append_fill[FIELD_W-1:0];
               for (int i = 0; i < tbl_count; i++) begin
                  l = tbl_len[i];
                  if (!placed && off <= pos) begin
                     add_piece(n, 1'b1, ast, len);
                     placed = 1'b1;
                     add_piece(n, tbl_src[i], tbl_start[i], l);
                  end else if (!placed && off < pos + l) begin
                     add_piece(n, tbl_src[i], tbl_start[i], off - pos);
                     add_piece(n, 1'b1, ast, len);
                     add_piece(n, tbl_src[i], tbl_start[i] + FIELD_W'(off - pos),
                               l - (off - pos));
                     placed = 1'b1;
                  end else begin
                     add_piece(n, tbl_src[i], tbl_start[i], l);
                  end
                  pos += l;
               end
               if (!placed) add_piece(n, 1'b1, ast, len);
               if (n > MAX_PIECES) push_rsp(ST_FULL, '0);
               else begin
                  for (int i = 0; i < n; i++) begin
                     tbl_src[i] = nxt_src[i];
                     tbl_start[i] = nxt_start[i];
                     tbl_len[i] = nxt_len[i];
                  end
                  tbl_count = n;
                  append_fill += len;
                  push_rsp(ST_OK, ast);
               end
            end
         end
         default: begin
            if (off + len > tot) push_rsp(ST_RANGE, '0);
            else if (len == 0) push_rsp(ST_OK, '0);
            else begin
               for (int i = 0; i < tbl_count; i++) begin
                  l = tbl_len[i];
                  pe = pos + l;
                  if (pe <= off || pos >= off + len) begin
                     add_piece(n, tbl_src[i], tbl_start[i], l);
                  end else begin
                     if (off > pos) add_piece(n, tbl_src[i], tbl_start[i], off - pos);
                     if (off + len < pe)
                        add_piece(n, tbl_src[i], tbl_start[i] + FIELD_W'(off + len - pos),
                                  pe - off - len);
                  end
                  pos = pe;
               end
               if (n > MAX_PIECES) push_rsp(ST_FULL, '0);
               else begin
                  for (int i = 0; i < n; i++) begin
                     tbl_src[i] = nxt_src[i];
                     tbl_start[i] = nxt_start[i];
                     tbl_len[i] = nxt_len[i];
                  end
                  tbl_count = n;
                  push_rsp(ST_OK, '0);
               end
            end
         end
      endcase
   endfunction

   // driver: bursts of requests with random gaps, changed on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         // hold the request until it is taken
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
         req_item <= pending_reqs.pop_front();
         start <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: predict on acceptance, check each response
   always @(posedge clock) begin
      rsp_type want;
      taken <= start && !busy && !reset;
      if (!reset && csr_wr_en) orig_len = csr_wr_data;
      if (!reset && start && !busy) predict_edit(req_item);
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %h", rsp_item);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               errors++;
            end
            if (rsp_item.append_start !== want.append_start) begin
               $error("append_start: expected %h, got %h", want.append_start,
                      rsp_item.append_start);
               errors++;
            end
            if (rsp_item.piece_source !== want.piece_source) begin
               $error("piece_source: expected %0d, got %0d", want.piece_source,
                      rsp_item.piece_source);
               errors++;
            end
            if (rsp_item.piece_start !== want.piece_start) begin
               $error("piece_start: expected %h, got %h", want.piece_start,
                      rsp_item.piece_start);
               errors++;
            end
            if (rsp_item.piece_length !== want.piece_length) begin
               $error("piece_length: expected %h, got %h", want.piece_length,
                      rsp_item.piece_length);
               errors++;
            end
            if (rsp_item.piece_total !== want.piece_total) begin
               $error("piece_total: expected %0d, got %0d", want.piece_total,
                      rsp_item.piece_total);
               errors++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_item.last);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_type make_req(opcode_type op, longint off, longint len);
      req_type q;
      q.opcode = op;
      q.offset = off[FIELD_W-1:0];
      q.length = len[FIELD_W-1:0];
      return q;
   endfunction

   task automatic queue_req(opcode_type op, longint off, longint len);
      while (pending_reqs.size() >= 2) @(negedge clock);
      pending_reqs.push_back(make_req(op, off, len));
   endtask

   // wait until the engine is idle with nothing outstanding
   task automatic drain();
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_orig_len(logic [FIELD_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // mostly well-formed edits on the current text, some noise
   task automatic random_phase(int count);
      int sel;
      longint tot, off, len;
      req_type q;
      for (int k = 0; k < count; k++) begin
         while (pending_reqs.size() >= 1) @(negedge clock);
         tot = text_length();
         sel = $urandom_range(0, 99);
         off = $urandom_range(0, (tot > 32'hFFFFF) ? 32'hFFFFF : tot);
         if (sel < 10) begin
            q = make_req(opcode_type'($urandom_range(0, 3)), $urandom, $urandom);
            queue_req(q.opcode, q.offset, q.length);
         end else if (sel < 55) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32'hFFFFF)
                                                : $urandom_range(0, 40);
            queue_req(OP_INSERT, off, len);
         end else if (sel < 85) begin
            len = tot - off;
            if (len > 64 && $urandom_range(0, 7) != 0) len = 64;
            len = $urandom_range(0, len);
            queue_req(OP_DELETE, off, len);
         end else if (sel < 96) begin
            queue_req(OP_LIST, 0, 0);
         end else begin
            queue_req(OP_INIT, 0, 0);
         end
      end
   endtask

   initial begin
      logic [FIELD_W-1:0] lens[5];
      errors = 0;
      tbl_count = 0;
      append_fill = 0;
      orig_len = '0;
      start = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      taken = 1'b0;
      burst_left = 1;
      gap_left = 0;
      idle_cycles = 0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part on an empty original text
      write_orig_len('0);
      queue_req(OP_LIST, 0, 0);
      queue_req(OP_INIT, 0, 0);
      queue_req(OP_LIST, 0, 0);
      queue_req(OP_INSERT, 0, 5);
      queue_req(OP_INSERT, 5, 3);
      queue_req(OP_INSERT, 2, 1);
      queue_req(OP_LIST, 0, 0);
      queue_req(OP_DELETE, 1, 3);
      queue_req(OP_DELETE, 0, 0);
      queue_req(OP_INSERT, 3, 0);
      queue_req(OP_INSERT, 32'hFFFFF, 32'hFFFFF);
      queue_req(OP_DELETE, 0, 32'hFFFFF);
      queue_req(OP_INSERT, 0, 32'hFFFFF);
      queue_req(OP_INIT, 0, 0);
      queue_req(OP_INSERT, 0, 32'hFFFFF);
      queue_req(OP_INSERT, 32'hFFFFF, 1);
      queue_req(OP_INSERT, 0, 1);
      queue_req(OP_LIST, 0, 0);
      queue_req(OP_DELETE, 32'hFFFFF, 1);

      // random phases over several original lengths
      lens[0] = 20'hFFFFF;
      lens[1] = 20'd1;
      lens[2] = 20'd0;
      lens[3] = $urandom_range(2, 20'hFFFFF);
      lens[4] = $urandom_range(2, 300);
      foreach (lens[p]) begin
         write_orig_len(lens[p]);
         queue_req(OP_INIT, 0, 0);
         random_phase(78);
      end

      drain();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
